/* rtl/tnvw_pkg.sv */
`default_nettype none

package tnvw_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int CW_EFF = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam int CW_PAD = 32 - CW_EFF;

	localparam int MUL_W = 34;
	localparam int DIV_STEPS = 160;
	localparam int LOG_STEPS = 24;
	localparam int POW_STEPS = 30;

	localparam logic [15:0] EXP_RESET = 16'd1229;
	localparam logic [63:0] GMAX = 64'hFFFF_FFFE_FFFF_FFFF;
	localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
	localparam logic [63:0] POW_HALF = 64'h0000_0000_2000_0000;
	localparam logic [32:0] POW_ONE = 33'h0_4000_0000;
	localparam logic [48:0] ROUND_Q14 = 49'd8192;
	localparam logic [31:0] WEIGHT_ONE = 32'h0001_0000;
	localparam logic [31:0] WEIGHT_MAX = 32'hFFFF_FFFF;

	localparam logic [1:0] CORNER_A = 2'd0;
	localparam logic [1:0] CORNER_B = 2'd1;
	localparam logic [1:0] CORNER_C = 2'd2;

	typedef logic [5:0][31:0] corner_t;

	typedef struct packed {
		logic [31:0] weight;
		logic        degenerate;
		logic        saturated;
	} res_t;

	function automatic logic signed [32:0] sext_coord(input logic [31:0] raw);
		logic signed [31:0] s;
		s = signed'(raw << CW_PAD) >>> CW_PAD;
		return 33'(s);
	endfunction

	function automatic logic [1:0] fit_shift(input logic [5:0][32:0] v);
		logic [1:0]         s_min;
		logic               ok;
		logic signed [32:0] sh;
		s_min = 2'd3;
		for (int s = 2; s >= 0; s--) begin
			ok = 1'b1;
			for (int i = 0; i < 6; i++) begin
				sh = $signed(v[i]) >>> s;
				if (!(sh[32:30] == 3'b000 || sh[32:30] == 3'b111)) ok = 1'b0;
			end
			if (ok) s_min = 2'(s);
		end
		return s_min;
	endfunction

	// root factor t_j of 2^(2^-j) in Q2.30
	function automatic logic [31:0] pow_root(input int j);
		logic [63:0] t;
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] b;
		t = 64'd1 << 31;
		for (int n = 0; n < j; n++) begin
			x = t << 30;
			res = 64'd0;
			b = 64'd1 << 62;
			for (int i = 0; i < 32; i++) begin
				if (b > x) b = b >> 2;
			end
			for (int i = 0; i < 32; i++) begin
				if (b != 64'd0) begin
					if (x >= res + b) begin
						x = x - (res + b);
						res = (res >> 1) + b;
					end else begin
						res = res >> 1;
					end
					b = b >> 2;
				end
			end
			t = res;
		end
		return t[31:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/tnvw_mul.sv */
`default_nettype none

module tnvw_mul import tnvw_pkg::*; (
	input  wire logic                      clk,
	input  wire logic signed [MUL_W-1:0]   a,
	input  wire logic signed [MUL_W-1:0]   b,
	output logic signed [2*MUL_W-1:0]      prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

`default_nettype wire

/* rtl/tnvw_div.sv */
`default_nettype none

module tnvw_div import tnvw_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [127:0] num,
	input  wire logic [127:0] den,
	output logic              done,
	output logic [63:0]       quo,
	output logic              sat
);

	logic         run_q;
	logic         done_q;
	logic [7:0]   cnt_q;
	logic [127:0] rem_q;
	logic [127:0] nsh_q;
	logic [127:0] den_q;
	logic [63:0]  quo_q;
	logic         over_q;
	logic [127:0] rem_sh;
	logic         take;

	assign rem_sh = {rem_q[126:0], nsh_q[127]};
	assign take = rem_q[127] || (rem_sh >= den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 8'd1;
				if (cnt_q == 8'(DIV_STEPS - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nsh_q <= num;
			den_q <= den;
			quo_q <= '0;
			over_q <= 1'b0;
		end else if (run_q) begin
			rem_q <= take ? rem_sh - den_q : rem_sh;
			nsh_q <= {nsh_q[126:0], 1'b0};
			over_q <= over_q | quo_q[63];
			quo_q <= {quo_q[62:0], take};
		end
	end

	assign done = done_q;
	assign quo = quo_q;
	assign sat = over_q || (quo_q > GMAX);

`ifndef SYNTH
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n) start |-> !run_q)
		else $error("divider started while running");
	a_done_stop: assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !run_q)
		else $error("divider done while running");
`endif

endmodule

`default_nettype wire

/* rtl/tnvw_core.sv */
`default_nettype none

module tnvw_core import tnvw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire corner_t     c0,
	input  wire corner_t     c1,
	input  wire corner_t     c2,
	input  wire logic [15:0] exponent,
	output logic             busy,
	output logic             res_valid,
	input  wire logic        res_ready,
	output res_t             res
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_FIT, ST_MA, ST_MB, ST_MV, ST_MLO, ST_MHL, ST_MHH, ST_MACC,
		ST_VEND, ST_NSH, ST_DIV, ST_NORM, ST_LOG_ISS, ST_LOG_TAKE, ST_PRD_ISS,
		ST_PRD_TAKE, ST_POW, ST_POW_TAKE, ST_FIN, ST_DONE
	} state_t;

	state_t state_q, state_d;
	res_t   res_q, res_d;

	logic [5:0][32:0]  e_raw_q;
	logic [5:0][32:0]  d_raw_q;
	logic [5:0][30:0]  e_q;
	logic [5:0][30:0]  d_q;
	logic [1:0]        sp_q, sn_q, sp_c, sn_c;
	logic [1:0]        vi_q, k_q;
	logic signed [63:0] t_q;
	logic [61:0]       vmag_q;
	logic [127:0]      acc_q, den_q, num_q;
	logic [63:0]       nrm_q;
	logic [5:0]        lp_q;
	logic [31:0]       m_q;
	logic [23:0]       lfrac_q;
	logic [4:0]        lint_q;
	logic [4:0]        cnt_q;
	logic [3:0]        yi_q;
	logic [29:0]       f_q;
	logic [32:0]       pacc_q;
	logic [4:0]        jc_q;
	logic              sat_q;

	logic signed [30:0] opa, opb, opc, opd;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [2*MUL_W-1:0] prod;
	logic signed [63:0] prod64, v_c, v_abs;
	logic [32:0]  mm;
	logic [44:0]  y_c;
	logic [63:0]  psum;
	logic [48:0]  fsh, fw;
	logic         norm_go;
	logic         div_start, div_done, div_sat;
	logic [63:0]  div_quo;
	logic [31:0]  tw [POW_STEPS];

	for (genvar j = 0; j < POW_STEPS; j++) begin : g_tw
		assign tw[j] = pow_root(j + 1);
	end

	tnvw_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	assign div_start = (state_q == ST_NSH);

	tnvw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q << {sn_q, 1'b0}),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo),
		.sat    (div_sat)
	);

	assign sp_c = fit_shift(e_raw_q);
	assign sn_c = fit_shift(d_raw_q);
	assign prod64 = prod[63:0];
	assign v_c = t_q - prod64;
	assign v_abs = v_c[63] ? -v_c : v_c;
	assign mm = prod[63:31];
	assign y_c = prod[44:0];
	assign psum = prod[63:0] + POW_HALF;
	assign fsh = 49'(pacc_q) << yi_q;
	assign fw = fsh + ROUND_Q14;
	assign norm_go = !nrm_q[63] && (lp_q > 6'd32);

	always_comb begin
		opa = '0;
		opb = '0;
		opc = '0;
		opd = '0;
		case ({vi_q, k_q})
			4'h0: begin opa = e_q[1]; opb = e_q[5]; opc = e_q[2]; opd = e_q[4]; end
			4'h1: begin opa = e_q[2]; opb = e_q[3]; opc = e_q[0]; opd = e_q[5]; end
			4'h2: begin opa = e_q[0]; opb = e_q[4]; opc = e_q[1]; opd = e_q[3]; end
			4'h4: begin opa = d_q[3]; opb = e_q[0]; opc = d_q[0]; opd = e_q[3]; end
			4'h5: begin opa = d_q[3]; opb = e_q[1]; opc = d_q[0]; opd = e_q[4]; end
			4'h6: begin opa = d_q[3]; opb = e_q[2]; opc = d_q[0]; opd = e_q[5]; end
			4'h8: begin opa = d_q[4]; opb = e_q[0]; opc = d_q[1]; opd = e_q[3]; end
			4'h9: begin opa = d_q[4]; opb = e_q[1]; opc = d_q[1]; opd = e_q[4]; end
			4'hA: begin opa = d_q[4]; opb = e_q[2]; opc = d_q[1]; opd = e_q[5]; end
			4'hC: begin opa = d_q[5]; opb = e_q[0]; opc = d_q[2]; opd = e_q[3]; end
			4'hD: begin opa = d_q[5]; opb = e_q[1]; opc = d_q[2]; opd = e_q[4]; end
			4'hE: begin opa = d_q[5]; opb = e_q[2]; opc = d_q[2]; opd = e_q[5]; end
			default: begin opa = '0; opb = '0; opc = '0; opd = '0; end
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MA: begin mul_a = MUL_W'(opa); mul_b = MUL_W'(opb); end
			ST_MB: begin mul_a = MUL_W'(opc); mul_b = MUL_W'(opd); end
			ST_MLO: begin mul_a = MUL_W'(vmag_q[30:0]); mul_b = MUL_W'(vmag_q[30:0]); end
			ST_MHL: begin mul_a = MUL_W'(vmag_q[61:31]); mul_b = MUL_W'(vmag_q[30:0]); end
			ST_MHH: begin mul_a = MUL_W'(vmag_q[61:31]); mul_b = MUL_W'(vmag_q[61:31]); end
			ST_LOG_ISS: begin mul_a = MUL_W'(m_q); mul_b = MUL_W'(m_q); end
			ST_PRD_ISS: begin mul_a = MUL_W'({lint_q, lfrac_q}); mul_b = MUL_W'(exponent); end
			ST_POW: begin mul_a = MUL_W'(pacc_q); mul_b = MUL_W'(tw[jc_q]); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		state_d = state_q;
		res_d = res_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_FIT;
			ST_FIT: state_d = ST_MA;
			ST_MA: state_d = ST_MB;
			ST_MB: state_d = ST_MV;
			ST_MV: state_d = ST_MLO;
			ST_MLO: state_d = ST_MHL;
			ST_MHL: state_d = ST_MHH;
			ST_MHH: state_d = ST_MACC;
			ST_MACC: state_d = (k_q == 2'd2) ? ST_VEND : ST_MA;
			ST_VEND: begin
				if (vi_q == 2'd0 && acc_q == '0) begin
					res_d = '{weight: WEIGHT_ONE, degenerate: 1'b1, saturated: 1'b0};
					state_d = ST_DONE;
				end else if (vi_q == 2'd3) begin
					state_d = ST_NSH;
				end else begin
					state_d = ST_MA;
				end
			end
			ST_NSH: state_d = ST_DIV;
			ST_DIV: if (div_done) state_d = ST_NORM;
			ST_NORM: if (!norm_go) state_d = ST_LOG_ISS;
			ST_LOG_ISS: state_d = ST_LOG_TAKE;
			ST_LOG_TAKE: state_d = (cnt_q == 5'(LOG_STEPS - 1)) ? ST_PRD_ISS : ST_LOG_ISS;
			ST_PRD_ISS: state_d = ST_PRD_TAKE;
			ST_PRD_TAKE: begin
				if (y_c[44:40] != 5'd0) begin
					res_d = '{weight: WEIGHT_MAX, degenerate: 1'b0, saturated: 1'b1};
					state_d = ST_DONE;
				end else begin
					state_d = ST_POW;
				end
			end
			ST_POW: begin
				if (f_q[29]) state_d = ST_POW_TAKE;
				else if (jc_q == 5'(POW_STEPS - 1)) state_d = ST_FIN;
			end
			ST_POW_TAKE: state_d = (jc_q == 5'(POW_STEPS - 1)) ? ST_FIN : ST_POW;
			ST_FIN: begin
				if (fw[48:46] != 3'd0) begin
					res_d = '{weight: WEIGHT_MAX, degenerate: 1'b0, saturated: 1'b1};
				end else begin
					res_d = '{weight: fw[45:14], degenerate: 1'b0, saturated: sat_q};
				end
				state_d = ST_DONE;
			end
			ST_DONE: if (res_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_q <= '0;
		end else begin
			state_q <= state_d;
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				for (int k = 0; k < 3; k++) begin
					e_raw_q[k] <= sext_coord(c1[k]) - sext_coord(c0[k]);
					e_raw_q[3 + k] <= sext_coord(c2[k]) - sext_coord(c0[k]);
					d_raw_q[k] <= sext_coord(c1[3 + k]) - sext_coord(c0[3 + k]);
					d_raw_q[3 + k] <= sext_coord(c2[3 + k]) - sext_coord(c0[3 + k]);
				end
			end
			ST_FIT: begin
				for (int i = 0; i < 6; i++) begin
					e_q[i] <= 31'($signed(e_raw_q[i]) >>> sp_c);
					d_q[i] <= 31'($signed(d_raw_q[i]) >>> sn_c);
				end
				sp_q <= sp_c;
				sn_q <= sn_c;
				vi_q <= '0;
				k_q <= '0;
				acc_q <= '0;
				num_q <= '0;
			end
			ST_MB: t_q <= prod64;
			ST_MV: vmag_q <= v_abs[61:0];
			ST_MHL: acc_q <= acc_q + 128'(prod[61:0]);
			ST_MHH: acc_q <= acc_q + (128'(prod[61:0]) << 32);
			ST_MACC: begin
				acc_q <= acc_q + (128'(prod[61:0]) << 62);
				if (k_q != 2'd2) k_q <= k_q + 2'd1;
			end
			ST_VEND: begin
				if (vi_q == 2'd0) den_q <= acc_q << {sp_q, 1'b0};
				else if (acc_q >= num_q) num_q <= acc_q;
				acc_q <= '0;
				k_q <= '0;
				vi_q <= vi_q + 2'd1;
			end
			ST_DIV: begin
				nrm_q <= (div_sat ? GMAX : div_quo) + ONE_Q32;
				lp_q <= 6'd63;
				sat_q <= div_sat;
			end
			ST_NORM: begin
				if (norm_go) begin
					nrm_q <= {nrm_q[62:0], 1'b0};
					lp_q <= lp_q - 6'd1;
				end else begin
					m_q <= nrm_q[63:32];
					lint_q <= lp_q[4:0];
					lfrac_q <= '0;
					cnt_q <= '0;
				end
			end
			ST_LOG_TAKE: begin
				m_q <= mm[32] ? mm[32:1] : mm[31:0];
				lfrac_q <= {lfrac_q[22:0], mm[32]};
				cnt_q <= cnt_q + 5'd1;
			end
			ST_PRD_TAKE: begin
				yi_q <= y_c[39:36];
				f_q <= y_c[35:6];
				pacc_q <= POW_ONE;
				jc_q <= '0;
			end
			ST_POW: begin
				if (!f_q[29]) begin
					f_q <= {f_q[28:0], 1'b0};
					jc_q <= jc_q + 5'd1;
				end
			end
			ST_POW_TAKE: begin
				pacc_q <= psum[62:30];
				f_q <= {f_q[28:0], 1'b0};
				jc_q <= jc_q + 5'd1;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res = res_q;

`ifndef SYNTH
	a_flat_one: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_q.degenerate |-> res_q.weight == WEIGHT_ONE && !res_q.saturated)
		else $error("flat triangle result not unit weight");
`endif

endmodule

`default_nettype wire

/* rtl/triangle_normal_variation_weight.sv */
`default_nettype none

// channel  | handshake               | payload
// ---------+-------------------------+-----------------------------------------
// in       | in_valid / in_stall     | pos_x..pos_z, norm_x..norm_z, corner
// out      | out_valid / out_stall   | weight, degenerate, saturated
// cfg      | cfg_we                  | cfg_data (weight_exponent)
//
// Corners A and B are stored; corner 3 is accepted and dropped. Corner C runs the
// cross and square terms on the shared multiplier, then the bit-serial divider,
// normalization, the log squarings and the power product. A flat triangle is done
// after its first cross product; a clip in the exponent product skips the power.
// in_stall is high while a triangle is in work or its result waits for the output
// register. Reset clears control and loads the default exponent.

module triangle_normal_variation_weight import tnvw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] pos_z,
	input  wire logic [31:0] norm_x,
	input  wire logic [31:0] norm_y,
	input  wire logic [31:0] norm_z,
	input  wire logic [1:0]  corner,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      weight,
	output logic             degenerate,
	output logic             saturated,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data
);

	corner_t     store_q [2];
	corner_t     cur;
	logic [15:0] exp_q;
	logic        accept;
	logic        core_busy;
	logic        res_valid;
	logic        res_ready;
	res_t        res;
	res_t        out_q;
	logic        out_valid_q;

	assign cur = {norm_z, norm_y, norm_x, pos_z, pos_y, pos_x};
	assign accept = in_valid && !in_stall;
	assign in_stall = core_busy;

	always_ff @(posedge clk) begin
		if (accept && corner == CORNER_A) store_q[0] <= cur;
		if (accept && corner == CORNER_B) store_q[1] <= cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= EXP_RESET;
		end else if (cfg_we) begin
			exp_q <= cfg_data;
		end
	end

	tnvw_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && corner == CORNER_C),
		.c0        (store_q[0]),
		.c1        (store_q[1]),
		.c2        (cur),
		.exponent  (exp_q),
		.busy      (core_busy),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign weight = out_q.weight;
	assign degenerate = out_q.degenerate;
	assign saturated = out_q.saturated;

`ifndef SYNTH
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && corner == CORNER_C |=> core_busy)
		else $error("triangle accepted without starting work");
`endif

endmodule

`default_nettype wire
